/* design/mhb_pkg.sv */
`timescale 1ns / 1ps

package mhb_pkg;

    localparam int VAL_W     = 32;
    localparam int POS_W     = 6;
    localparam int TALLY_W   = 6;
    localparam int CHILD_W   = POS_W + 2;
    localparam int DEPTH_DEF = 64;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
    } cand_t;

endpackage

/* design/mhb_pick.sv */
`timescale 1ns / 1ps

module mhb_pick
(
    input  mhb_pkg::cand_t               cand,
    input  logic [mhb_pkg::VAL_W-1:0]    probe_val,
    input  logic [mhb_pkg::POS_W-1:0]    probe_pos,
    input  logic                         probe_ok,
    output mhb_pkg::cand_t               pick
);

    // A strictly smaller probe replaces the candidate, so the candidate wins ties.
    always_comb
    begin
        if (probe_ok && (probe_val < cand.val))
        begin
            pick.pos = probe_pos;
            pick.val = probe_val;
        end
        else
        begin
            pick = cand;
        end
    end

endmodule

/* design/min_heap_build_swap_log_unit.sv */
`timescale 1ns / 1ps

// Values are loaded one per beat while busy is low; a beat that is not marked last leaves
// busy low. The beat marked last starts a bottom-up min-heap build, and busy stays high
// until the done record has been issued. The build runs on one shared compare unit and a
// store with one write port and two registered read ports: each internal node is fetched
// (S_NODE, S_KIDS) and its children compared (S_CMPL, S_CMPR), each swap adds two writes
// (S_SWAP, S_SWAP2) and, where the moved value still has children, two more compares, and
// S_DONE issues the done record. Every swap and the final done record appear for exactly
// one cycle with strobe high, and the receiver must take each one in that cycle since the
// block cannot hold results back.
module min_heap_build_swap_log_unit
#(
    parameter int DEPTH = mhb_pkg::DEPTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [mhb_pkg::VAL_W-1:0]     value,
    input  logic                          last,
    output logic                          strobe,
    output logic                          is_swap,
    output logic [mhb_pkg::POS_W-1:0]     upper_pos,
    output logic [mhb_pkg::POS_W-1:0]     lower_pos,
    output logic [mhb_pkg::TALLY_W-1:0]   total_swaps,
    output logic                          overflow,
    output logic                          end_of_run
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int VW    = mhb_pkg::VAL_W;
    localparam int PW    = mhb_pkg::POS_W;
    localparam int TW    = mhb_pkg::TALLY_W;
    localparam int LW    = mhb_pkg::CHILD_W;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_NODE  = 8'b0000_0010,
        S_KIDS  = 8'b0000_0100,
        S_CMPL  = 8'b0000_1000,
        S_CMPR  = 8'b0001_0000,
        S_SWAP  = 8'b0010_0000,
        S_SWAP2 = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [TW-1:0]        tally_reg, tally_next;
    logic                 drop_reg, drop_next;
    logic [PW-1:0]        node_reg, node_next;
    logic [PW-1:0]        cur_reg, cur_next;
    logic [VW-1:0]        cur_val_reg, cur_val_next;
    logic [PW-1:0]        lc_reg, lc_next;
    mhb_pkg::cand_t       best_reg, best_next;

    logic                 strobe_reg, strobe_next;
    logic                 is_swap_reg, is_swap_next;
    logic [PW-1:0]        upper_reg, upper_next;
    logic [PW-1:0]        lower_reg, lower_next;
    logic [TW-1:0]        total_reg, total_next;
    logic                 ovf_reg, ovf_next;
    logic                 eor_reg, eor_next;

    logic [VW-1:0]        mem [0:DEPTH-1];
    logic                 rd_en;
    logic [AW-1:0]        rd_addr_a;
    logic [AW-1:0]        rd_addr_b;
    logic [VW-1:0]        rdata_a_reg;
    logic [VW-1:0]        rdata_b_reg;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [VW-1:0]        wr_data;

    mhb_pkg::cand_t       pick_cand;
    logic [VW-1:0]        pick_val;
    logic [PW-1:0]        pick_pos;
    logic                 pick_ok;
    mhb_pkg::cand_t       pick_out;

    logic                 accept;
    logic                 has_room;
    logic [CNT_W-1:0]     count_load;
    logic [LW-1:0]        start_w;
    logic [PW-1:0]        desc_pos;
    logic [LW-1:0]        desc_lc;
    logic [LW-1:0]        desc_rc;
    logic                 desc_ok;
    logic [LW-1:0]        rc_w;
    logic                 rc_ok;
    state_t               nn_state;
    logic [PW-1:0]        nn_node;

    assign accept   = start && (state_reg == S_IDLE);
    assign has_room = count_reg < CNT_W'(DEPTH);
    assign count_load = has_room ? (count_reg + CNT_W'(1)) : count_reg;
    assign start_w  = LW'(count_load) >> 1;

    assign desc_pos = (state_reg == S_SWAP2) ? best_reg.pos : cur_reg;
    assign desc_lc  = (LW'(desc_pos) << 1) + LW'(1);
    assign desc_rc  = desc_lc + LW'(1);
    assign desc_ok  = desc_lc < LW'(count_reg);

    assign rc_w  = LW'(lc_reg) + LW'(1);
    assign rc_ok = rc_w < LW'(count_reg);

    assign nn_state = (node_reg == '0) ? S_DONE : S_NODE;
    assign nn_node  = node_reg - PW'(1);

    assign rd_en     = (state_reg == S_NODE) || (state_reg == S_KIDS)
                       || (state_reg == S_SWAP2);
    assign rd_addr_a = (state_reg == S_NODE) ? cur_reg[AW-1:0] : desc_lc[AW-1:0];
    assign rd_addr_b = desc_rc[AW-1:0];

    always_comb
    begin
        if (state_reg == S_CMPR)
        begin
            pick_cand = best_reg;
            pick_val  = rdata_b_reg;
            pick_pos  = rc_w[PW-1:0];
            pick_ok   = rc_ok;
        end
        else
        begin
            pick_cand.pos = cur_reg;
            pick_cand.val = cur_val_reg;
            pick_val      = rdata_a_reg;
            pick_pos      = lc_reg;
            pick_ok       = 1'b1;
        end
    end

    mhb_pick u_pick
    (
        .cand      (pick_cand),
        .probe_val (pick_val),
        .probe_pos (pick_pos),
        .probe_ok  (pick_ok),
        .pick      (pick_out)
    );

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        tally_next   = tally_reg;
        drop_next    = drop_reg;
        node_next    = node_reg;
        cur_next     = cur_reg;
        cur_val_next = cur_val_reg;
        lc_next      = lc_reg;
        best_next    = best_reg;
        strobe_next  = 1'b0;
        is_swap_next = is_swap_reg;
        upper_next   = upper_reg;
        lower_next   = lower_reg;
        total_next   = total_reg;
        ovf_next     = ovf_reg;
        eor_next     = eor_reg;
        wr_en        = 1'b0;
        wr_addr      = count_reg[AW-1:0];
        wr_data      = value;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    count_next = count_load;
                    if (has_room)
                    begin
                        wr_en = 1'b1;
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                    if (last)
                    begin
                        if (start_w == '0)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            node_next  = start_w[PW-1:0] - PW'(1);
                            cur_next   = start_w[PW-1:0] - PW'(1);
                            state_next = S_NODE;
                        end
                    end
                end
            end
            S_NODE:
            begin
                state_next = S_KIDS;
            end
            S_KIDS:
            begin
                cur_val_next = rdata_a_reg;
                if (desc_ok)
                begin
                    lc_next    = desc_lc[PW-1:0];
                    state_next = S_CMPL;
                end
                else
                begin
                    state_next = nn_state;
                    node_next  = nn_node;
                    cur_next   = nn_node;
                end
            end
            S_CMPL:
            begin
                best_next  = pick_out;
                state_next = S_CMPR;
            end
            S_CMPR:
            begin
                best_next = pick_out;
                if (pick_out.pos == cur_reg)
                begin
                    state_next = nn_state;
                    node_next  = nn_node;
                    cur_next   = nn_node;
                end
                else
                begin
                    state_next = S_SWAP;
                end
            end
            S_SWAP:
            begin
                wr_en        = 1'b1;
                wr_addr      = cur_reg[AW-1:0];
                wr_data      = best_reg.val;
                tally_next   = tally_reg + TW'(1);
                strobe_next  = 1'b1;
                is_swap_next = 1'b1;
                upper_next   = cur_reg;
                lower_next   = best_reg.pos;
                total_next   = tally_reg + TW'(1);
                ovf_next     = drop_reg;
                eor_next     = 1'b0;
                state_next   = S_SWAP2;
            end
            S_SWAP2:
            begin
                wr_en    = 1'b1;
                wr_addr  = best_reg.pos[AW-1:0];
                wr_data  = cur_val_reg;
                cur_next = best_reg.pos;
                if (desc_ok)
                begin
                    lc_next    = desc_lc[PW-1:0];
                    state_next = S_CMPL;
                end
                else
                begin
                    state_next = nn_state;
                    node_next  = nn_node;
                    cur_next   = nn_node;
                end
            end
            S_DONE:
            begin
                strobe_next  = 1'b1;
                is_swap_next = 1'b0;
                upper_next   = '0;
                lower_next   = '0;
                total_next   = tally_reg;
                ovf_next     = drop_reg;
                eor_next     = 1'b1;
                count_next   = '0;
                tally_next   = '0;
                drop_next    = 1'b0;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_a_reg <= mem[rd_addr_a];
            rdata_b_reg <= mem[rd_addr_b];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            tally_reg  <= '0;
            drop_reg   <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            tally_reg  <= tally_next;
            drop_reg   <= drop_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg    <= node_next;
        cur_reg     <= cur_next;
        cur_val_reg <= cur_val_next;
        lc_reg      <= lc_next;
        best_reg    <= best_next;
        is_swap_reg <= is_swap_next;
        upper_reg   <= upper_next;
        lower_reg   <= lower_next;
        total_reg   <= total_next;
        ovf_reg     <= ovf_next;
        eor_reg     <= eor_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign strobe      = strobe_reg;
    assign is_swap     = is_swap_reg;
    assign upper_pos   = upper_reg;
    assign lower_pos   = lower_reg;
    assign total_swaps = total_reg;
    assign overflow    = ovf_reg;
    assign end_of_run  = eor_reg;

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("Sequencer state is not one-hot.");

    a_swap_goes_down: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && is_swap) |-> (lower_pos > upper_pos))
        else $error("Swap record does not move toward a child.");

    a_run_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && end_of_run) |-> (count_reg == '0 && tally_reg == '0 && !busy))
        else $error("Run state not cleared after the done record.");

    a_child_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMPL) |-> (CNT_W'(lc_reg) < count_reg))
        else $error("Left child lies outside the loaded elements.");

    a_swap_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWAP) |=>
            (state_reg == S_SWAP2 && $stable(best_reg) && $stable(cur_reg)))
        else $error("Swap did not complete as a write pair.");

endmodule
